### hdl/scfc_pkg.sv
// Shared types, sizes and codes for the size-class free chunk cache.
package scfc_pkg;

  // Sizing
  localparam int unsigned NUM_BINS  = 64;
  localparam int unsigned BIN_DEPTH = 8;
  localparam int unsigned ADDR_BITS = 48;

  localparam int unsigned STK_DEPTH = NUM_BINS * BIN_DEPTH;
  localparam int unsigned BIN_AW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned STK_AW    = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(BIN_DEPTH + 1);
  localparam int unsigned TOT_W     = $clog2(STK_DEPTH + 1);
  localparam int unsigned STK_W     = (ADDR_BITS < 48) ? ADDR_BITS : 48;
  localparam int unsigned CMP_W     = 8;

  localparam logic [3:0] FILL_LIMIT_RST = 4'd7;

  // Operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  bin_index;
    logic [47:0] chunk_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] chunk_address_res;
    logic [3:0]  bin_count;
    logic [9:0]  held_total;
    logic        last;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture request, read bin count
    logic decide;      // apply update, issue stack read
    logic flush_step;  // move to next older entry
    logic out_plain;   // load output word from decision
    logic out_stack;   // load output word from stack data
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_stack;
    logic last_word;
  } dp_sts_t;

endpackage

### hdl/scfc_dp.sv
// Datapath: request latch, bin count memory, chunk stack memory, totals and output word.
module scfc_dp import scfc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  req_t          req_i,
  input  logic          cfg_we_i,
  input  logic [3:0]    cfg_wdata_i,
  input  dp_cmd_t       cmd_i,
  output dp_sts_t       sts_o,
  output res_t          res_o
);

  // Request latch
  logic [1:0]        op_q;
  logic [6:0]        bin_q;
  logic [STK_W-1:0]  addr_q;

  // Bin count memory with per-bin valid flags
  logic [CNT_W-1:0]  fill_mem [NUM_BINS];
  logic [NUM_BINS-1:0] fill_vld_q;
  logic [CNT_W-1:0]  fill_rd_q;
  logic              fill_vld_rd_q;

  // Chunk stack memory
  logic [STK_W-1:0]  stk_mem [STK_DEPTH];
  logic [STK_W-1:0]  stk_rd_q;

  logic [3:0]        fill_limit_q;
  logic [TOT_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]  k_q, k_d, k_sel;
  logic [1:0]        res_status_q, res_status_d;
  logic [CNT_W-1:0]  res_count_q, res_count_d;
  res_t              res_q;

  logic [CNT_W-1:0]  n;
  logic              oor;
  logic [CMP_W-1:0]  limit;
  logic              needs_stack;
  logic              fill_we;
  logic [CNT_W-1:0]  fill_wdata;
  logic              stk_we, stk_re;
  logic [BIN_AW-1:0] bin_lo;
  logic [STK_AW-1:0] stk_base, stk_addr;
  logic              last_word;

  assign bin_lo   = bin_q[BIN_AW-1:0];
  assign n        = fill_vld_rd_q ? fill_rd_q : '0;
  assign oor      = {1'b0, bin_q} >= 8'(NUM_BINS);
  assign limit    = ({4'd0, fill_limit_q} < CMP_W'(BIN_DEPTH)) ?
                    {4'd0, fill_limit_q} : CMP_W'(BIN_DEPTH);
  assign stk_base = STK_AW'(bin_lo) * STK_AW'(BIN_DEPTH);
  assign last_word = (op_q != OP_FLUSH) || (k_q == '0);

  // Decide the outcome of the latched request
  always_comb begin
    res_status_d = ST_OK;
    res_count_d  = n;
    total_d      = total_q;
    fill_we      = 1'b0;
    fill_wdata   = n;
    stk_we       = 1'b0;
    needs_stack  = 1'b0;
    k_d          = n - CNT_W'(1);
    if (oor) begin
      res_status_d = ST_RANGE;
      res_count_d  = '0;
    end else begin
      case (op_q)
        OP_ALLOC: begin
          if (n == '0) begin
            res_status_d = ST_EMPTY;
          end else begin
            res_count_d = n - CNT_W'(1);
            fill_we     = 1'b1;
            fill_wdata  = n - CNT_W'(1);
            total_d     = total_q - TOT_W'(1);
            needs_stack = 1'b1;
          end
        end
        OP_FREE: begin
          if (CMP_W'(n) >= limit) begin
            res_status_d = ST_FULL;
          end else begin
            res_count_d = n + CNT_W'(1);
            fill_we     = 1'b1;
            fill_wdata  = n + CNT_W'(1);
            total_d     = total_q + TOT_W'(1);
            stk_we      = 1'b1;
          end
        end
        OP_FLUSH: begin
          if (n == '0) begin
            res_status_d = ST_EMPTY;
          end else begin
            res_count_d = '0;
            fill_we     = 1'b1;
            fill_wdata  = '0;
            total_d     = total_q - TOT_W'(n);
            needs_stack = 1'b1;
          end
        end
        default: begin
          res_status_d = ST_OK;
        end
      endcase
    end
  end

  // Pick the stack slot: top (or next free slot for a free) on decision, next older on flush step
  assign k_sel    = cmd_i.decide ? (needs_stack ? k_d : n) : (k_q - CNT_W'(1));
  assign stk_addr = stk_base + STK_AW'(k_sel);
  assign stk_re   = (cmd_i.decide && needs_stack) || cmd_i.flush_step;

  // Control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_vld_q   <= '0;
      total_q      <= '0;
      fill_limit_q <= FILL_LIMIT_RST;
    end else begin
      if (cfg_we_i) begin
        fill_limit_q <= cfg_wdata_i;
      end
      if (cmd_i.decide) begin
        total_q <= total_d;
        if (fill_we) begin
          fill_vld_q[bin_lo] <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q          <= req_i.operation;
      bin_q         <= req_i.bin_index;
      addr_q        <= STK_W'(req_i.chunk_address);
      fill_rd_q     <= fill_mem[req_i.bin_index[BIN_AW-1:0]];
      fill_vld_rd_q <= fill_vld_q[req_i.bin_index[BIN_AW-1:0]];
    end
    if (cmd_i.decide) begin
      res_status_q <= res_status_d;
      res_count_q  <= res_count_d;
      k_q          <= k_d;
      if (fill_we) begin
        fill_mem[bin_lo] <= fill_wdata;
      end
    end
    if (cmd_i.flush_step) begin
      k_q <= k_q - CNT_W'(1);
    end
  end

  // Stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && stk_we) begin
      stk_mem[stk_addr] <= addr_q;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_addr];
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_plain) begin
      res_q.status            <= res_status_q;
      res_q.chunk_address_res <= '0;
      res_q.bin_count         <= 4'(res_count_q);
      res_q.held_total        <= 10'(total_q);
      res_q.last              <= 1'b1;
    end else if (cmd_i.out_stack) begin
      res_q.status            <= ST_OK;
      res_q.chunk_address_res <= 48'(stk_rd_q);
      res_q.bin_count         <= 4'(res_count_q);
      res_q.held_total        <= 10'(total_q);
      res_q.last              <= last_word;
    end
  end

  assign res_o             = res_q;
  assign sts_o.needs_stack = needs_stack;
  assign sts_o.last_word   = last_word;

endmodule

### hdl/scfc_ctrl.sv
// Controller: sequences lookup, update and result delivery for one request at a time.
module scfc_ctrl import scfc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_RESP,
    S_STACK
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.decide = 1'b1;
        state_d = sts_i.needs_stack ? S_STACK : S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          cmd_o.out_plain = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_STACK: begin
        if (slot_free) begin
          cmd_o.out_stack = 1'b1;
          if (sts_i.last_word) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.flush_step = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold a word until taken, reload when the slot frees
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_plain || cmd_o.out_stack) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### hdl/size_class_free_chunk_cache.sv
// Top level of the size-class free chunk cache: per-bin LIFO stacks of freed chunk addresses.
//
//   port group       dir  handshake          word
//   in_*             in   valid / ready      req_t  (operation, bin_index, chunk_address)
//   out_*            out  valid / ready      res_t  (status, address, counts, last)
//   cfg_*            in   write enable only  fill_limit, 4 bits
//
// Alloc, free, no-op and rejected requests are accepted with a bin count memory read, then
// decided and updated (plus a stack read for an alloc that finds an entry), then delivered.
// A flush is accepted and decided the same way; the single-port stack memory then yields one
// entry per cycle unless the output stalls. Reset clears all counts at once through per-bin
// valid flags; no clearing pass is needed. A stalled output holds the sequence where it is.
module size_class_free_chunk_cache import scfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_res_o,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  scfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scfc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (out_res_o)
  );

endmodule
